/* rtl/bps_pkg.sv */
// Shared types, sizes and a helper function of the bucket priority stack.
package bps_pkg;

   localparam int CAPACITY     = 256;
   localparam int ELEMENT_BITS = 32;
   localparam int LEVEL_BITS   = 4;
   localparam int LEVELS       = 1 << LEVEL_BITS;
   localparam int ADDR_BITS    = $clog2(CAPACITY);
   localparam int COUNT_BITS   = ADDR_BITS + 1;

   localparam int REQ_FIELD_BITS = ELEMENT_BITS + LEVEL_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 2 + ELEMENT_BITS + LEVEL_BITS + COUNT_BITS + 1;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // Free list pointer value that means no released entry is waiting.
   localparam logic [COUNT_BITS-1:0] FREE_NONE = COUNT_BITS'(CAPACITY);
   localparam logic [COUNT_BITS-1:0] COUNT_FULL = COUNT_BITS'(CAPACITY);

   typedef enum logic {
      ACT_PUSH = 1'b0,
      ACT_POP  = 1'b1
   } bps_action_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_RANGE = 2'd3
   } bps_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_POP_LINK,
      ST_POP_HEAD,
      ST_POP_VALUE,
      ST_DONE
   } bps_state_type;

   typedef struct packed {
      bps_status_type            status;
      logic [ELEMENT_BITS-1:0]   top_element;
      logic [LEVEL_BITS-1:0]     top_level;
      logic [COUNT_BITS-1:0]     count;
      logic                      is_empty;
   } bps_result_type;

   // Highest set bit of the occupancy map, zero when no bucket is occupied.
   function automatic logic [LEVEL_BITS-1:0] highest_level(input logic [LEVELS-1:0] occ);
      logic [LEVEL_BITS-1:0] lv;
      lv = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (occ[i]) begin
            lv = LEVEL_BITS'(i);
         end
      end
      return lv;
   endfunction

endpackage

/* rtl/bps_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module bps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/bps_engine.sv */
// Sequencer and bookkeeping registers that drive the value, link and head memories.
module bps_engine import bps_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [LEVEL_BITS-1:0]   max_level,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bps_action_type          req_action,
   input  logic [ELEMENT_BITS-1:0] req_element,
   input  logic [LEVEL_BITS-1:0]   req_level,
   output logic                    result_valid,
   input  logic                    result_taken,
   output bps_result_type          result,
   output logic                    value_we,
   output logic [ADDR_BITS-1:0]    value_waddr,
   output logic [ELEMENT_BITS-1:0] value_wdata,
   output logic [ADDR_BITS-1:0]    value_raddr,
   input  logic [ELEMENT_BITS-1:0] value_rdata,
   output logic                    link_we,
   output logic [ADDR_BITS-1:0]    link_waddr,
   output logic [ADDR_BITS-1:0]    link_wdata,
   output logic [ADDR_BITS-1:0]    link_raddr,
   input  logic [ADDR_BITS-1:0]    link_rdata,
   output logic                    head_we,
   output logic [LEVEL_BITS-1:0]   head_waddr,
   output logic [ADDR_BITS-1:0]    head_wdata,
   output logic [LEVEL_BITS-1:0]   head_raddr,
   input  logic [ADDR_BITS-1:0]    head_rdata
);

   bps_state_type           state_ff, state_in;
   bps_status_type          status_ff, status_in;
   logic [ELEMENT_BITS-1:0] elem_ff, elem_in;
   logic [LEVEL_BITS-1:0]   level_ff, level_in;
   logic [ADDR_BITS-1:0]    node_ff, node_in;
   logic [LEVELS-1:0]       occupied_ff, occupied_in;
   logic [COUNT_BITS-1:0]   free_head_ff, free_head_in;
   logic [COUNT_BITS-1:0]   fresh_count_ff, fresh_count_in;
   logic [COUNT_BITS-1:0]   stored_count_ff, stored_count_in;
   logic [LEVEL_BITS-1:0]   top_ff, top_in;
   logic [ADDR_BITS-1:0]    top_head_ff, top_head_in;
   logic [ELEMENT_BITS-1:0] top_value_ff, top_value_in;

   logic                    start;
   logic                    free_avail;
   logic [ADDR_BITS-1:0]    alloc_node;
   logic                    push_range;
   logic                    push_full;
   logic                    pop_last;
   logic [LEVELS-1:0]       occ_after_pop;
   logic [LEVEL_BITS-1:0]   pop_next_top;

   assign result_valid = (state_ff == ST_DONE);
   assign req_ready    = (state_ff == ST_IDLE) || ((state_ff == ST_DONE) && result_taken);
   assign start        = req_valid && req_ready;

   assign free_avail = !free_head_ff[ADDR_BITS];
   assign alloc_node = free_avail ? free_head_ff[ADDR_BITS-1:0]
                                  : fresh_count_ff[ADDR_BITS-1:0];
   assign push_range = (req_level > max_level);
   assign push_full  = (stored_count_ff == COUNT_FULL);

   // A chain ends at an entry whose link points back at itself.
   assign pop_last = (link_rdata == top_head_ff);

   always_comb begin
      occ_after_pop = occupied_ff;
      if (pop_last) begin
         occ_after_pop[top_ff] = 1'b0;
      end
   end

   assign pop_next_top = highest_level(occ_after_pop);

   assign result.status      = status_ff;
   assign result.is_empty    = (stored_count_ff == '0);
   assign result.count       = stored_count_ff;
   assign result.top_level   = result.is_empty ? '0 : top_ff;
   assign result.top_element = result.is_empty ? '0 : top_value_ff;

   // Memory read ports; the read data arrives in the next cycle.
   assign link_raddr  = (req_action == ACT_PUSH) ? free_head_ff[ADDR_BITS-1:0] : top_head_ff;
   assign head_raddr  = start ? req_level : pop_next_top;
   assign value_raddr = (state_ff == ST_POP_HEAD) ? head_rdata : link_rdata;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff) inside
         ST_IDLE, ST_DONE: begin
            if (start) begin
               if (req_action == ACT_PUSH) begin
                  state_in = (push_range || push_full) ? ST_DONE : ST_PUSH;
               end else begin
                  state_in = (stored_count_ff == '0) ? ST_DONE : ST_POP_LINK;
               end
            end else if (state_ff == ST_DONE && result_taken) begin
               state_in = ST_IDLE;
            end
         end
         ST_PUSH: begin
            state_in = ST_DONE;
         end
         ST_POP_LINK: begin
            if (stored_count_ff == COUNT_BITS'(1)) begin
               state_in = ST_DONE;
            end else if (!pop_last) begin
               state_in = ST_POP_VALUE;
            end else begin
               state_in = ST_POP_HEAD;
            end
         end
         ST_POP_HEAD: begin
            state_in = ST_POP_VALUE;
         end
         ST_POP_VALUE: begin
            state_in = ST_DONE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      status_in       = status_ff;
      elem_in         = elem_ff;
      level_in        = level_ff;
      node_in         = node_ff;
      occupied_in     = occupied_ff;
      free_head_in    = free_head_ff;
      fresh_count_in  = fresh_count_ff;
      stored_count_in = stored_count_ff;
      top_in          = top_ff;
      top_head_in     = top_head_ff;
      top_value_in    = top_value_ff;
      value_we        = 1'b0;
      value_waddr     = node_ff;
      value_wdata     = elem_ff;
      link_we         = 1'b0;
      link_waddr      = node_ff;
      link_wdata      = node_ff;
      head_we         = 1'b0;
      head_waddr      = level_ff;
      head_wdata      = node_ff;

      unique case (state_ff) inside
         ST_IDLE, ST_DONE: begin
            if (start) begin
               elem_in  = req_element;
               level_in = req_level;
               node_in  = alloc_node;
               if (req_action == ACT_PUSH) begin
                  if (push_range) begin
                     status_in = STATUS_RANGE;
                  end else if (push_full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     status_in = STATUS_OK;
                  end
               end else begin
                  status_in = (stored_count_ff == '0) ? STATUS_EMPTY : STATUS_OK;
               end
            end
         end
         ST_PUSH: begin
            value_we    = 1'b1;
            link_we     = 1'b1;
            link_wdata  = occupied_ff[level_ff] ? head_rdata : node_ff;
            head_we     = 1'b1;
            occupied_in[level_ff] = 1'b1;
            stored_count_in = stored_count_ff + COUNT_BITS'(1);
            if (free_avail) begin
               free_head_in = (link_rdata == node_ff) ? FREE_NONE : {1'b0, link_rdata};
            end else begin
               fresh_count_in = fresh_count_ff + COUNT_BITS'(1);
            end
            if (stored_count_ff == '0 || level_ff >= top_ff) begin
               top_in       = level_ff;
               top_head_in  = node_ff;
               top_value_in = elem_ff;
            end
         end
         ST_POP_LINK: begin
            // Release the top entry onto the free list and unlink it from its bucket.
            link_we     = 1'b1;
            link_waddr  = top_head_ff;
            link_wdata  = free_avail ? free_head_ff[ADDR_BITS-1:0] : top_head_ff;
            free_head_in = {1'b0, top_head_ff};
            head_we     = !pop_last;
            head_waddr  = top_ff;
            head_wdata  = link_rdata;
            occupied_in = occ_after_pop;
            stored_count_in = stored_count_ff - COUNT_BITS'(1);
            top_in      = pop_next_top;
            if (!pop_last) begin
               top_head_in = link_rdata;
            end
         end
         ST_POP_HEAD: begin
            top_head_in = head_rdata;
         end
         ST_POP_VALUE: begin
            top_value_in = value_rdata;
         end
         default: begin
            status_in = status_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         status_ff       <= STATUS_OK;
         occupied_ff     <= '0;
         free_head_ff    <= FREE_NONE;
         fresh_count_ff  <= '0;
         stored_count_ff <= '0;
         top_ff          <= '0;
      end else begin
         state_ff        <= state_in;
         status_ff       <= status_in;
         occupied_ff     <= occupied_in;
         free_head_ff    <= free_head_in;
         fresh_count_ff  <= fresh_count_in;
         stored_count_ff <= stored_count_in;
         top_ff          <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      elem_ff      <= elem_in;
      level_ff     <= level_in;
      node_ff      <= node_in;
      top_head_ff  <= top_head_in;
      top_value_ff <= top_value_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      stored_count_ff <= COUNT_FULL)
      else $error("stored count exceeds capacity");

   assert property (@(posedge clock) disable iff (reset)
      (stored_count_ff == '0) == (occupied_ff == '0))
      else $error("occupancy map disagrees with stored count");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action == ACT_PUSH && req_level > max_level
      |=> state_ff == ST_DONE && status_ff == STATUS_RANGE)
      else $error("push above maximum level was not rejected");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PUSH |=> stored_count_ff == $past(stored_count_ff) + COUNT_BITS'(1))
      else $error("push did not add one entry");

endmodule

/* rtl/bucket_priority_stack.sv */
// Top level of the bucket priority stack: memories, level register and result register.
//
// Requests arrive on the req_ stream: tuser carries the action (push or pop), tdata the
// element and its priority level. Every request beat yields exactly one response beat on
// the rsp_ stream with the status, the element and level now on top, the count and an
// empty flag. A pop removes the newest element of the highest occupied level.
// The csr_ channel writes the highest level a push may use; it is always ready and is
// meant to be written while no request is in flight.
// A push passes through ST_PUSH and a pop through ST_POP_LINK and ST_POP_VALUE, with
// ST_POP_HEAD between them when it empties the top bucket and the head of the next
// occupied level has to be fetched; a pop that removes the last element ends after
// ST_POP_LINK, and a rejected request goes straight to ST_DONE. The steps follow from
// the registered reads of the link, head and value memories, each read feeding the next.
// The engine's result is copied into the output register once that register is free.
// If the receiver stalls, the finished result waits in that register while the next
// request is taken and worked on; the engine then holds its own result until the
// register frees, and stops taking requests meanwhile.
// Reset empties the stack and sets the maximum level to fifteen; no memory clearing pass
// is needed, since chains never reach an entry that was not written.
module bucket_priority_stack import bps_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // element, level, zero fill
   input  logic                     req_tuser,  // action
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // status, top_element, top_level, count, is_empty
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [LEVEL_BITS-1:0]    csr_wdata   // max_level
);

   logic [LEVEL_BITS-1:0]    max_level_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                    out_free;
   logic                    result_valid;
   bps_result_type          result;
   bps_action_type          req_action;

   logic                    value_we;
   logic [ADDR_BITS-1:0]    value_waddr;
   logic [ELEMENT_BITS-1:0] value_wdata;
   logic [ADDR_BITS-1:0]    value_raddr;
   logic [ELEMENT_BITS-1:0] value_rdata;
   logic                    link_we;
   logic [ADDR_BITS-1:0]    link_waddr;
   logic [ADDR_BITS-1:0]    link_wdata;
   logic [ADDR_BITS-1:0]    link_raddr;
   logic [ADDR_BITS-1:0]    link_rdata;
   logic                    head_we;
   logic [LEVEL_BITS-1:0]   head_waddr;
   logic [ADDR_BITS-1:0]    head_wdata;
   logic [LEVEL_BITS-1:0]   head_raddr;
   logic [ADDR_BITS-1:0]    head_rdata;

   assign csr_ready  = 1'b1;
   assign req_action = bps_action_type'(req_tuser);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   bps_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .max_level    (max_level_ff),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_action   (req_action),
      .req_element  (req_tdata[ELEMENT_BITS-1:0]),
      .req_level    (req_tdata[REQ_FIELD_BITS-1:ELEMENT_BITS]),
      .result_valid (result_valid),
      .result_taken (out_free),
      .result       (result),
      .value_we     (value_we),
      .value_waddr  (value_waddr),
      .value_wdata  (value_wdata),
      .value_raddr  (value_raddr),
      .value_rdata  (value_rdata),
      .link_we      (link_we),
      .link_waddr   (link_waddr),
      .link_wdata   (link_wdata),
      .link_raddr   (link_raddr),
      .link_rdata   (link_rdata),
      .head_we      (head_we),
      .head_waddr   (head_waddr),
      .head_wdata   (head_wdata),
      .head_raddr   (head_raddr),
      .head_rdata   (head_rdata)
   );

   bps_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(CAPACITY)) u_value_ram (
      .clock   (clock),
      .wr_en   (value_we),
      .wr_addr (value_waddr),
      .wr_data (value_wdata),
      .rd_addr (value_raddr),
      .rd_data (value_rdata)
   );

   bps_ram #(.WIDTH(ADDR_BITS), .DEPTH(CAPACITY)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   bps_ram #(.WIDTH(ADDR_BITS), .DEPTH(LEVELS)) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_waddr),
      .wr_data (head_wdata),
      .rd_addr (head_raddr),
      .rd_data (head_rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = result_valid;
         rsp_data_in  = RSP_DATA_BITS'({result.is_empty, result.count, result.top_level,
                                        result.top_element, result.status});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_level_ff <= LEVEL_BITS'(LEVELS - 1);
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            max_level_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
